// ----- rtl/core/thpd_pkg.sv -----
package thpd_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int PEAK_BITS       = 23;
   localparam int HOLD_BITS       = 4;
   localparam int FALL_BITS       = 3;
   localparam int EVENT_BITS      = 2;
   localparam int INDEX_BITS      = 32;
   localparam int CSR_IDX_BITS    = 2;

   localparam int RSP_FIELD_BITS  = EVENT_BITS + PEAK_BITS + INDEX_BITS;
   localparam int RSP_BITS        = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [PEAK_BITS-1:0] PEAK_MAX = 23'h7f_ffff;

   localparam logic [PEAK_BITS-1:0] TRIGGER_RST = 23'd167772;
   localparam logic [HOLD_BITS-1:0] HOLDOFF_RST = 4'd3;
   localparam logic [FALL_BITS-1:0] FALLS_RST   = 3'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TRIGGER = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLDOFF = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FALLS   = 2'd2;

   localparam logic [1:0] PH_ARMED  = 2'd0;
   localparam logic [1:0] PH_SEED   = 2'd1;
   localparam logic [1:0] PH_SEARCH = 2'd2;
   localparam logic [1:0] PH_WAIT   = 2'd3;

   localparam logic [EVENT_BITS-1:0] EV_NONE = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_PEAK = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_HIT  = 2'd2;

   typedef struct packed {
      logic [PEAK_BITS-1:0] trigger_level;
      logic [HOLD_BITS-1:0] holdoff_peaks;
      logic [FALL_BITS-1:0] falls_to_end;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] sample_index;
      logic [PEAK_BITS-1:0]  peak_value;
      logic [EVENT_BITS-1:0] event_res;
   } rsp_type;

endpackage

// ----- rtl/core/thpd_level.sv -----
module thpd_level #(
   parameter int SAMPLE_BITS = thpd_pkg::SAMPLE_BITS_DEF
) (
   input  logic [SAMPLE_BITS-1:0]         sample_code,
   output logic [thpd_pkg::PEAK_BITS-1:0] level
);
   import thpd_pkg::*;

   logic [31:0] magnitude;

   always_comb begin
      magnitude = 32'(sample_code[SAMPLE_BITS-2:0]);
      if (sample_code[SAMPLE_BITS-1]) begin
         level = '0;
      end else if (magnitude > 32'(PEAK_MAX)) begin
         level = PEAK_MAX;
      end else begin
         level = magnitude[PEAK_BITS-1:0];
      end
   end

endmodule

// ----- rtl/core/thpd_core.sv -----
module thpd_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [thpd_pkg::PEAK_BITS-1:0] level,
   input  thpd_pkg::cfg_type              cfg,
   output thpd_pkg::rsp_type              result
);
   import thpd_pkg::*;

   logic [1:0]            phase_ff, phase_in;
   logic [PEAK_BITS-1:0]  max_ff, max_in;
   logic [FALL_BITS-1:0]  fall_ff, fall_in;
   logic [PEAK_BITS-1:0]  prev_ff, prev_in;
   logic [HOLD_BITS-1:0]  hold_ff, hold_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;

   logic [FALL_BITS-1:0]  limit;
   logic [FALL_BITS-1:0]  fall_next;
   logic [PEAK_BITS-1:0]  max_next;
   logic [HOLD_BITS-1:0]  hold_dec;
   logic                  hit;

   always_comb begin
      limit     = (cfg.falls_to_end == '0) ? FALL_BITS'(1) : cfg.falls_to_end;
      max_next  = (level > max_ff) ? level : max_ff;
      fall_next = (level > max_ff) ? '0 : fall_ff + FALL_BITS'(1);
      hold_dec  = (hold_ff != '0) ? hold_ff - HOLD_BITS'(1) : hold_ff;
      hit       = (max_next > prev_ff) && (hold_dec == '0);

      phase_in = phase_ff;
      max_in   = max_ff;
      fall_in  = fall_ff;
      prev_in  = prev_ff;
      hold_in  = hold_ff;
      count_in = count_ff + INDEX_BITS'(1);

      result.event_res    = EV_NONE;
      result.peak_value   = '0;
      result.sample_index = count_in;

      unique case (phase_ff)
         PH_ARMED: begin
            if (level > cfg.trigger_level) begin
               phase_in = PH_SEED;
            end
         end
         PH_SEED: begin
            max_in   = level;
            fall_in  = '0;
            phase_in = PH_SEARCH;
         end
         PH_SEARCH: begin
            max_in  = max_next;
            fall_in = fall_next;
            if (fall_next >= limit) begin
               result.peak_value = max_next;
               result.event_res  = hit ? EV_HIT : EV_PEAK;
               hold_in  = hit ? cfg.holdoff_peaks : hold_dec;
               prev_in  = max_next;
               fall_in  = '0;
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (level == '0) begin
               phase_in = PH_ARMED;
            end
         end
         default: begin
            phase_in = PH_ARMED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ARMED;
         max_ff   <= '0;
         fall_ff  <= '0;
         prev_ff  <= '0;
         hold_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         max_ff   <= max_in;
         fall_ff  <= fall_in;
         prev_ff  <= prev_in;
         hold_ff  <= hold_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/threshold_peak_hit_detector.sv -----
// A sample item passes through the input register and then the result register before its result item is presented.
// Throughput: one sample item per cycle; the input register and the result register
// each advance whenever the next stage is free, so rsp_tready low only stalls.
// Reset (synchronous, active high) clears the detector state and sample counter and
// restores the register defaults.
module threshold_peak_hit_detector #(
   parameter int SAMPLE_BITS = thpd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [SAMPLE_BITS-1:0] sample_code, upper bits zero fill
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] event_res, [24:2] peak_value, [56:25] sample_index, upper bits zero
   output logic [thpd_pkg::RSP_BITS-1:0]       rsp_tdata,
   input  logic                                csr_wen,
   input  logic [thpd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [thpd_pkg::PEAK_BITS-1:0]      csr_wdata
);
   import thpd_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_data_ff, out_data_in;

   logic                   req_take;
   logic                   out_free;
   logic                   step;
   logic [PEAK_BITS-1:0]   level;
   rsp_type                result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_BITS'(out_data_ff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_TRIGGER: cfg_in.trigger_level = csr_wdata;
            CSR_HOLDOFF: cfg_in.holdoff_peaks = csr_wdata[HOLD_BITS-1:0];
            CSR_FALLS:   cfg_in.falls_to_end  = csr_wdata[FALL_BITS-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end

      s1_valid_in  = req_take ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
      s1_sample_in = req_take ? req_tdata[SAMPLE_BITS-1:0] : s1_sample_ff;
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
      out_data_in  = step ? result : out_data_ff;
   end

   thpd_level #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_level (
      .sample_code(s1_sample_ff),
      .level      (level)
   );

   thpd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .level (level),
      .cfg   (cfg_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level <= TRIGGER_RST;
         cfg_ff.holdoff_peaks <= HOLDOFF_RST;
         cfg_ff.falls_to_end  <= FALLS_RST;
         s1_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff <= s1_sample_in;
      out_data_ff  <= out_data_in;
   end

endmodule

// ----- dv/tb_threshold_peak_hit_detector.sv -----
`timescale 1ns / 100ps

module tb_threshold_peak_hit_detector;
   import thpd_pkg::*;

   localparam int SAMPLE_W = SAMPLE_BITS_DEF;
   localparam int REQ_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_LATENCY = 2;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int NUM_PHASES = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [SAMPLE_W-1:0]   code;
      bit                    fixed;
      logic [EVENT_BITS-1:0] ev;
      logic [PEAK_BITS-1:0]  pk;
   } sample_entry_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]     rsp_tdata;
   logic                    csr_wen = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [PEAK_BITS-1:0]    csr_wdata = '0;

   threshold_peak_hit_detector #(
      .SAMPLE_BITS(SAMPLE_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Detector state as the block should hold it.
   cfg_type               cfg;
   logic [1:0]            det_phase;
   logic [PEAK_BITS-1:0]  det_max;
   logic [FALL_BITS-1:0]  det_falls;
   logic [PEAK_BITS-1:0]  det_prev_peak;
   logic [HOLD_BITS-1:0]  det_holdoff;
   logic [INDEX_BITS-1:0] det_count;

   sample_entry_type sample_q[$];
   rsp_type          result_q[$];
   sample_entry_type directed_rows[20];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  burst_left = 0;
   bit  no_gaps = 0;
   bit  hold_rsp = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type next_detection(logic [SAMPLE_W-1:0] code);
      rsp_type              r;
      logic [PEAK_BITS-1:0] lvl;
      logic [FALL_BITS-1:0] ends_at;
      logic                 hit;
      r = '0;
      if (code[SAMPLE_W-1]) begin
         lvl = '0;
      end else if (code > SAMPLE_W'(PEAK_MAX)) begin
         lvl = PEAK_MAX;
      end else begin
         lvl = code[PEAK_BITS-1:0];
      end
      ends_at = (cfg.falls_to_end == 0) ? FALL_BITS'(1) : cfg.falls_to_end;
      det_count = det_count + 1'b1;
      case (det_phase)
         PH_ARMED: begin
            if (lvl > cfg.trigger_level) det_phase = PH_SEED;
         end
         PH_SEED: begin
            det_max = lvl;
            det_falls = '0;
            det_phase = PH_SEARCH;
         end
         PH_SEARCH: begin
            if (lvl > det_max) begin
               det_max = lvl;
               det_falls = '0;
            end else begin
               det_falls = det_falls + 1'b1;
            end
            if (det_falls >= ends_at) begin
               if (det_holdoff != 0) det_holdoff = det_holdoff - 1'b1;
               hit = (det_max > det_prev_peak) && (det_holdoff == 0);
               if (hit) det_holdoff = cfg.holdoff_peaks;
               det_prev_peak = det_max;
               r.event_res = hit ? EV_HIT : EV_PEAK;
               r.peak_value = det_max;
               det_falls = '0;
               det_phase = PH_WAIT;
            end
         end
         default: begin
            if (lvl == 0) det_phase = PH_ARMED;
         end
      endcase
      r.sample_index = det_count;
      return r;
   endfunction

   function automatic void write_model_reg(logic [CSR_IDX_BITS-1:0] idx,
                                           logic [PEAK_BITS-1:0] val);
      case (idx)
         CSR_TRIGGER: cfg.trigger_level = val;
         CSR_HOLDOFF: cfg.holdoff_peaks = val[HOLD_BITS-1:0];
         CSR_FALLS:   cfg.falls_to_end = val[FALL_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [PEAK_BITS-1:0] level_above(logic [PEAK_BITS-1:0] lo);
      if (lo >= PEAK_MAX) return PEAK_MAX;
      return PEAK_BITS'($urandom_range(int'(PEAK_MAX), int'(lo) + 1));
   endfunction

   function automatic logic [SAMPLE_W-1:0] quiet_code();
      if ($urandom_range(3) == 0) return '0;
      return {1'b1, (SAMPLE_W-1)'($urandom)};
   endfunction

   task automatic send_entry(sample_entry_type e);
      if (burst_left == 0) begin
         if (!no_gaps) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                               : $urandom_range(12, 1);
      end
      sample_q.push_back(e);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(e.code);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_code(logic [SAMPLE_W-1:0] code);
      sample_entry_type e;
      e.code = code;
      e.fixed = 1'b0;
      e.ev = EV_NONE;
      e.pk = '0;
      send_entry(e);
   endtask

   // One trigger, a rise to a random top, enough non-rising samples to end the
   // search, and a quiet sample to rearm; now and then plain noise instead.
   task automatic send_pulse(output int count);
      logic [PEAK_BITS-1:0] top;
      logic [PEAK_BITS-1:0] lvl;
      int                   ends_at;
      int                   k;
      count = 0;
      if ($urandom_range(4) == 0) begin
         k = $urandom_range(6, 1);
         repeat (k) send_code(SAMPLE_W'($urandom));
         count = k;
      end else begin
         ends_at = (cfg.falls_to_end == 0) ? 1 : int'(cfg.falls_to_end);
         repeat ($urandom_range(2)) begin
            send_code(quiet_code());
            count++;
         end
         send_code({1'b0, level_above(cfg.trigger_level)});
         top = PEAK_BITS'($urandom_range(int'(PEAK_MAX), 1));
         lvl = PEAK_BITS'($urandom_range(int'(top)));
         send_code({1'b0, lvl});
         count += 2;
         repeat ($urandom_range(3)) begin
            lvl = PEAK_BITS'($urandom_range(int'(top), int'(lvl)));
            send_code({1'b0, lvl});
            count++;
         end
         send_code({1'b0, top});
         count++;
         k = 0;
         while (k < ends_at) begin
            if ($urandom_range(7) == 0 && top < PEAK_MAX) begin
               top = level_above(top);
               send_code({1'b0, top});
               k = 0;
            end else begin
               send_code({1'b0, ($urandom_range(3) == 0) ? top
                                : PEAK_BITS'($urandom_range(int'(top)))});
               k++;
            end
            count++;
         end
         repeat ($urandom_range(1)) begin
            send_code({1'b0, PEAK_BITS'($urandom)});
            count++;
         end
         send_code(quiet_code());
         count++;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sample_q.size() != 0 || result_q.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic program_settings(logic [PEAK_BITS-1:0] trig, logic [HOLD_BITS-1:0] hold,
                                   logic [FALL_BITS-1:0] falls);
      logic [CSR_IDX_BITS-1:0] idx_list[4];
      logic [PEAK_BITS-1:0]    val_list[4];
      idx_list = '{CSR_TRIGGER, CSR_HOLDOFF, CSR_FALLS, CSR_SPARE};
      val_list[0] = trig;
      val_list[1] = {(PEAK_BITS-HOLD_BITS)'($urandom), hold};
      val_list[2] = {(PEAK_BITS-FALL_BITS)'($urandom), falls};
      val_list[3] = PEAK_BITS'($urandom);
      for (int i = 0; i < 4; i++) begin
         csr_wen <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= val_list[i];
         @(posedge clock);
         write_model_reg(idx_list[i], val_list[i]);
      end
      csr_wen <= 1'b0;
   endtask

   always @(posedge clock) begin : accept_mon
      sample_entry_type e;
      rsp_type          r;
      if (!reset && req_tvalid && req_tready) begin
         e = sample_q.pop_front();
         r = next_detection(e.code);
         if (e.fixed) begin
            r.event_res = e.ev;
            r.peak_value = e.pk;
         end
         result_q.push_back(r);
      end
   end

   always @(posedge clock) begin : result_mon
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
         if (result_q.size() == 0) begin
            $error("result item with nothing expected, sample_index %0d", got.sample_index);
            fail_count++;
         end else begin
            want = result_q.pop_front();
            if (got.event_res !== want.event_res) begin
               $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
               fail_count++;
            end
            if (got.peak_value !== want.peak_value) begin
               $error("peak_value: expected %0d, actual %0d", want.peak_value,
                      got.peak_value);
               fail_count++;
            end
            if (got.sample_index !== want.sample_index) begin
               $error("sample_index: expected %0d, actual %0d", want.sample_index,
                      got.sample_index);
               fail_count++;
            end
         end
      end
   end

   // The result side switches between stall patterns and honors a long hold request.
   initial begin : rsp_stall
      int mode;
      int span;
      forever begin
         mode = $urandom_range(3);
         span = $urandom_range(80, 16);
         repeat (span) begin
            @(posedge clock);
            if (hold_rsp) begin
               rsp_tready <= 1'b0;
               repeat (RSP_HOLD_CYCLES) @(posedge clock);
               hold_rsp = 0;
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(1));
               2: rsp_tready <= !rsp_tready;
               default: rsp_tready <= ($urandom_range(7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : main_seq
      int                   sent;
      int                   n;
      logic [PEAK_BITS-1:0] trig;
      logic [HOLD_BITS-1:0] hold;
      logic [FALL_BITS-1:0] falls;

      cfg.trigger_level = TRIGGER_RST;
      cfg.holdoff_peaks = HOLDOFF_RST;
      cfg.falls_to_end = FALLS_RST;
      det_phase = PH_ARMED;
      det_max = '0;
      det_falls = '0;
      det_prev_peak = '0;
      det_holdoff = '0;
      det_count = '0;

      // Rows after reset use the register defaults.
      directed_rows = '{
         '{24'h800000, 1'b1, EV_NONE, 23'd0},
         '{24'h000000, 1'b1, EV_NONE, 23'd0},
         '{24'h7fffff, 1'b1, EV_NONE, 23'd0},
         '{24'd100000, 1'b1, EV_NONE, 23'd0},
         '{24'd200000, 1'b0, EV_NONE, 23'd0},
         '{24'd150000, 1'b0, EV_NONE, 23'd0},
         '{24'd150000, 1'b1, EV_HIT,  23'd200000},
         '{24'd5,      1'b0, EV_NONE, 23'd0},
         '{24'hffffff, 1'b0, EV_NONE, 23'd0},
         '{24'd167772, 1'b1, EV_NONE, 23'd0},
         '{24'd167773, 1'b0, EV_NONE, 23'd0},
         '{24'd300000, 1'b0, EV_NONE, 23'd0},
         '{24'd300000, 1'b0, EV_NONE, 23'd0},
         '{24'd1,      1'b0, EV_NONE, 23'd0},
         '{24'h000000, 1'b0, EV_NONE, 23'd0},
         '{24'h7fffff, 1'b0, EV_NONE, 23'd0},
         '{24'h7fffff, 1'b0, EV_NONE, 23'd0},
         '{24'h7ffffe, 1'b0, EV_NONE, 23'd0},
         '{24'h000000, 1'b0, EV_NONE, 23'd0},
         '{24'h800000, 1'b0, EV_NONE, 23'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_entry(directed_rows[i]);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results();
         case (ph)
            0: begin trig = '0;       hold = '0;       falls = '0;         end
            1: begin trig = PEAK_MAX; hold = '1;       falls = '1;         end
            2: begin trig = 23'd1000; hold = '1;       falls = 3'd1;       end
            3: begin trig = '0;       hold = '0;       falls = '1;         end
            default: begin
               trig = ($urandom_range(1) == 0) ? PEAK_BITS'($urandom_range(200000))
                                               : PEAK_BITS'($urandom);
               hold = HOLD_BITS'($urandom);
               falls = FALL_BITS'($urandom);
            end
         endcase
         program_settings(trig, hold, falls);
         no_gaps = (ph == 4);
         if (ph == 4) hold_rsp = 1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            send_pulse(n);
            sent += n;
         end
      end

      drain_results();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
